>>> src/pce_pkg.sv
// shared constants and types for the permutation cycle extractor
`default_nettype none
package pce_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int SIZE_W      = IDX_W + 1;
  localparam int SIZE_RESET  = MAX_ENTRIES;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WALK,
    ST_NONE
  } state_t;

endpackage
`default_nettype wire

>>> src/pce_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module pce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/permutation_cycle_extractor.sv
// top level: permutation table, scan and cycle walk sequencer, apb register
// operation: a load is written into the table at the accepting edge; an extract scans 1 entry per
// cycle from position 0, then walks 1 element per cycle; each beat is registered onto valid
// busy: held through an extract until its last beat, so no new start is taken before then; an
// extract gives at most size beats with size = min(perm_size, 64), one no-cycle beat if none is left
// reset: clears the sequencer and strobe, perm_size to 64; table contents stay undefined
`default_nettype none
module permutation_cycle_extractor
  import pce_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              action,
  input  wire logic [IDX_W-1:0]  position,
  input  wire logic [IDX_W-1:0]  target,
  output logic                   valid,
  output logic                   found,
  output logic      [IDX_W-1:0]  cycle_element,
  output logic                   last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  state_t state, state_next;

  logic [SIZE_W-1:0] perm_size;
  logic [SIZE_W-1:0] size_eff;
  logic [IDX_W-1:0]  cur;
  logic [IDX_W-1:0]  start_pos;
  logic [SIZE_W-1:0] n;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [IDX_W-1:0]  ram_rdata;

  logic              accept;
  logic              hit;
  logic              stop;
  logic              scan_end;
  logic [IDX_W-1:0]  first_pos;
  logic              emit;
  logic              emit_found;
  logic              emit_last;
  logic [IDX_W-1:0]  emit_elem;

  // apb register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_size <= SIZE_W'(SIZE_RESET);
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      perm_size <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (!paddr[2]) begin
      prdata = {{(32-SIZE_W){1'b0}}, perm_size};
    end
  end

  assign size_eff = (perm_size > SIZE_W'(MAX_ENTRIES)) ? SIZE_W'(MAX_ENTRIES) : perm_size;

  // table
  pce_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign hit       = (ram_rdata != cur);
  assign first_pos = (state == ST_SCAN) ? cur : start_pos;
  assign stop      = (ram_rdata == first_pos)
                  || ({1'b0, ram_rdata} >= size_eff)
                  || ((n + SIZE_W'(1)) >= size_eff);
  assign scan_end  = (({1'b0, cur} + SIZE_W'(1)) >= size_eff);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && action == ACT_EXTRACT) begin
          state_next = (size_eff == '0) ? ST_NONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = stop ? ST_IDLE : ST_WALK;
        end else if (scan_end) begin
          state_next = ST_NONE;
        end
      end
      ST_WALK: begin
        if (stop) begin
          state_next = ST_IDLE;
        end
      end
      ST_NONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = cur;
    ram_wdata  = cur;
    ram_raddr  = '0;
    emit       = 1'b0;
    emit_found = 1'b1;
    emit_last  = 1'b0;
    emit_elem  = cur;
    case (state)
      ST_IDLE: begin
        ram_waddr = position;
        ram_wdata = target;
        ram_we    = accept && (action == ACT_LOAD);
      end
      ST_SCAN: begin
        ram_raddr = hit ? ram_rdata : cur + IDX_W'(1);
        ram_we    = hit;
        emit      = hit;
        emit_last = stop;
      end
      ST_WALK: begin
        ram_raddr = ram_rdata;
        ram_we    = 1'b1;
        emit      = 1'b1;
        emit_last = stop;
      end
      ST_NONE: begin
        emit       = 1'b1;
        emit_found = 1'b0;
        emit_last  = 1'b1;
        emit_elem  = '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    cur           <= ram_raddr;
    found         <= emit_found;
    last          <= emit_last;
    cycle_element <= emit_elem;
    if (state == ST_IDLE) begin
      n <= '0;
    end else if (emit) begin
      n <= n + SIZE_W'(1);
    end
    if (state == ST_SCAN && hit) begin
      start_pos <= cur;
    end
  end

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    (valid && !found) |-> last)
    else $error("no-cycle beat not marked last");

  a_walk_continues: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |=> valid)
    else $error("gap inside an extracted cycle");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (valid && last) |=> !valid)
    else $error("beat after the last one of an extract");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_LOAD) |=> !valid)
    else $error("load produced a result beat");

endmodule
`default_nettype wire
